>>> hdl/edfjs_pkg.sv
// Shared types and constants for the earliest-deadline-first job scheduler.
package edfjs_pkg;

   localparam int TIME_W     = 16;
   localparam int SLACK_W    = 17;
   localparam int SUM_W      = 32;
   localparam int RAN_SLOT_W = 4;

   typedef logic [TIME_W-1:0]         time_type;
   typedef logic signed [SLACK_W-1:0] slack_type;
   typedef logic [SUM_W-1:0]          sum_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic decr;
      logic run;
   } cell_ctrl_type;

   typedef struct packed {
      logic      valid;
      slack_type slack;
      time_type  arrival;
      time_type  remaining;
   } cand_type;

endpackage

>>> hdl/edfjs_cell.sv
// One job slot of the scheduler chain: holds a job and passes the best candidate onward.
module edfjs_cell #(
   parameter int SLOT_W     = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  edfjs_pkg::cell_ctrl_type ctrl,
   input  edfjs_pkg::time_type     tick,
   input  edfjs_pkg::time_type     load_arrival,
   input  edfjs_pkg::time_type     load_exec,
   input  edfjs_pkg::time_type     load_deadline,
   input  edfjs_pkg::cand_type     cand_in,
   input  logic [SLOT_W-1:0]       slot_in,
   output edfjs_pkg::cand_type     cand_out,
   output logic [SLOT_W-1:0]       slot_out
);
   import edfjs_pkg::*;

   logic              used_ff, used_in;
   time_type          arrival_ff, arrival_in;
   time_type          remaining_ff, remaining_in;
   slack_type         slack_ff, slack_in;
   cand_type          cand_ff, cand_in_next;
   logic [SLOT_W-1:0] slot_ff, slot_in_next;
   logic              eligible;
   logic              better;

   always_comb begin
      eligible = used_ff && (arrival_ff <= tick) && (remaining_ff != '0);
      better   = eligible && (!cand_in.valid || (slack_ff < cand_in.slack));
      if (better) begin
         cand_in_next.valid     = 1'b1;
         cand_in_next.slack     = slack_ff;
         cand_in_next.arrival   = arrival_ff;
         cand_in_next.remaining = remaining_ff;
         slot_in_next           = SLOT_W'(CELL_INDEX);
      end else begin
         cand_in_next = cand_in;
         slot_in_next = slot_in;
      end
   end

   always_comb begin
      used_in      = used_ff;
      arrival_in   = arrival_ff;
      remaining_in = remaining_ff;
      slack_in     = slack_ff;
      if (ctrl.load) begin
         used_in      = 1'b1;
         arrival_in   = load_arrival;
         remaining_in = load_exec;
         slack_in     = slack_type'({1'b0, load_deadline}) - slack_type'({1'b0, load_arrival});
      end else if (ctrl.decr) begin
         if (eligible && !slack_ff[SLACK_W-1]) begin
            slack_in = slack_ff - slack_type'(1);
         end
      end else if (ctrl.run) begin
         remaining_in = remaining_ff - time_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff   <= arrival_in;
      remaining_ff <= remaining_in;
      slack_ff     <= slack_in;
      cand_ff      <= cand_in_next;
      slot_ff      <= slot_in_next;
   end

   assign cand_out = cand_ff;
   assign slot_out = slot_ff;

endmodule

>>> hdl/edf_job_scheduler.sv
// Top level of the earliest-deadline-first job scheduler: request control and cell chain.
//
// A load request is answered with one rsp_valid strobe in the cycle after it is
// taken, and busy stays low, so loads can be issued every cycle while no tick
// request is in progress. For a tick request, every slot's slack is updated in
// parallel as it is accepted, the ST_SCAN state carries the best candidate down
// the row of slot cells one cell per cycle, and ST_FINISH retires the winner and
// registers the result; busy is high until the result strobe. Each result is on
// the rsp_ ports for exactly one cycle and cannot be held off by the receiver.
module edf_job_scheduler #(
   parameter int JOB_SLOTS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  edfjs_pkg::time_type       req_arrival_time,
   input  edfjs_pkg::time_type       req_exec_time,
   input  edfjs_pkg::time_type       req_deadline_time,
   output logic                      rsp_valid,
   output logic                      rsp_load_accepted,
   output logic                      rsp_ran_valid,
   output logic [edfjs_pkg::RAN_SLOT_W-1:0] rsp_ran_slot,
   output logic                      rsp_job_completed,
   output edfjs_pkg::time_type       rsp_job_turnaround,
   output logic                      rsp_deadline_missed,
   output edfjs_pkg::sum_type        rsp_turnaround_total,
   output edfjs_pkg::time_type       rsp_tick_now
);
   import edfjs_pkg::*;

   localparam int SLOT_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam int LOAD_W = $clog2(JOB_SLOTS + 1);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [LOAD_W-1:0] jobs_loaded_ff, jobs_loaded_in;
   time_type          tick_ff, tick_in;
   sum_type           sum_ff, sum_in;

   logic load_go, tick_go, finish;

   cand_type          cand_chain [JOB_SLOTS+1];
   logic [SLOT_W-1:0] slot_chain [JOB_SLOTS+1];
   cand_type          best;
   logic [SLOT_W-1:0] best_slot;

   logic                  full;
   time_type              new_rem;
   logic [TIME_W:0]       turn_wide;
   time_type              turn;
   logic [SUM_W:0]        sum_wide;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  load_acc_ff, load_acc_in;
   logic                  ran_ff, ran_in;
   logic [RAN_SLOT_W-1:0] ran_slot_ff, ran_slot_in;
   logic                  done_ff, done_in;
   time_type              turn_ff, turn_in;
   logic                  missed_ff, missed_in;
   sum_type               total_ff, total_in;
   time_type              tick_now_ff, tick_now_in;

   // next state
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && (req_type == REQ_TICK)) begin
               state_in    = ST_SCAN;
               scan_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + SLOT_W'(1);
            if (scan_cnt_ff == SLOT_W'(JOB_SLOTS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      busy    = 1'b1;
      load_go = 1'b0;
      tick_go = 1'b0;
      finish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy    = 1'b0;
            load_go = start && (req_type == REQ_LOAD);
            tick_go = start && (req_type == REQ_TICK);
         end
         ST_SCAN: begin
            busy = 1'b1;
         end
         ST_FINISH: begin
            finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign cand_chain[0] = '0;
   assign slot_chain[0] = '0;
   assign best          = cand_chain[JOB_SLOTS];
   assign best_slot     = slot_chain[JOB_SLOTS];

   for (genvar i = 0; i < JOB_SLOTS; i++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.load = load_go && (jobs_loaded_ff == LOAD_W'(i));
      assign ctrl.decr = tick_go;
      assign ctrl.run  = finish && best.valid && (best_slot == SLOT_W'(i));

      edfjs_cell #(
         .SLOT_W     (SLOT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .tick          (tick_ff),
         .load_arrival  (req_arrival_time),
         .load_exec     (req_exec_time),
         .load_deadline (req_deadline_time),
         .cand_in       (cand_chain[i]),
         .slot_in       (slot_chain[i]),
         .cand_out      (cand_chain[i+1]),
         .slot_out      (slot_chain[i+1])
      );
   end

   // retire and result
   always_comb begin
      full      = (jobs_loaded_ff == LOAD_W'(JOB_SLOTS));
      new_rem   = best.remaining - time_type'(1);
      turn_wide = {1'b0, tick_ff} + (TIME_W+1)'(1) - {1'b0, best.arrival};
      turn      = turn_wide[TIME_W] ? '1 : turn_wide[TIME_W-1:0];

      jobs_loaded_in = jobs_loaded_ff;
      tick_in        = tick_ff;
      sum_in         = sum_ff;
      sum_wide       = {1'b0, sum_ff};

      rsp_valid_in = 1'b0;
      load_acc_in  = 1'b0;
      ran_in       = 1'b0;
      ran_slot_in  = '0;
      done_in      = 1'b0;
      turn_in      = '0;
      missed_in    = 1'b0;
      total_in     = sum_ff;
      tick_now_in  = tick_ff;

      if (load_go) begin
         rsp_valid_in = 1'b1;
         load_acc_in  = !full;
         if (!full) begin
            jobs_loaded_in = jobs_loaded_ff + LOAD_W'(1);
         end
      end else if (finish) begin
         rsp_valid_in = 1'b1;
         tick_in      = tick_ff + time_type'(1);
         if (best.valid) begin
            ran_in      = 1'b1;
            ran_slot_in = RAN_SLOT_W'(best_slot);
            missed_in   = (best.slack == '0) && (new_rem != '0);
            if (new_rem == '0) begin
               done_in  = 1'b1;
               turn_in  = turn;
               sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(turn);
               sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            end
         end
         total_in = sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         jobs_loaded_ff <= '0;
         tick_ff        <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         jobs_loaded_ff <= jobs_loaded_in;
         tick_ff        <= tick_in;
         sum_ff         <= sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      load_acc_ff <= load_acc_in;
      ran_ff      <= ran_in;
      ran_slot_ff <= ran_slot_in;
      done_ff     <= done_in;
      turn_ff     <= turn_in;
      missed_ff   <= missed_in;
      total_ff    <= total_in;
      tick_now_ff <= tick_now_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_load_accepted    = load_acc_ff;
   assign rsp_ran_valid        = ran_ff;
   assign rsp_ran_slot         = ran_slot_ff;
   assign rsp_job_completed    = done_ff;
   assign rsp_job_turnaround   = turn_ff;
   assign rsp_deadline_missed  = missed_ff;
   assign rsp_turnaround_total = total_ff;
   assign rsp_tick_now         = tick_now_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(load_go) || $past(finish)))
      else $error("response strobe without a finished request");

   a_done_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (ran_ff && !missed_ff))
      else $error("completion reported with a miss or without a run");

   a_sum_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (sum_ff >= $past(sum_ff)))
      else $error("turnaround total decreased");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      finish |=> (tick_ff == time_type'($past(tick_ff) + time_type'(1))))
      else $error("tick did not advance by one on retire");

endmodule

>>> tb/sv/edf_job_scheduler_tb.sv
// Self-checking testbench for edf_job_scheduler: directed jobs and random requests.
`timescale 1ns / 100ps

module edf_job_scheduler_tb;
   import edfjs_pkg::*;

   localparam int JOB_SLOTS   = 16;
   localparam int QUIET_LIMIT = 5000;
   localparam int REPORT_CAP  = 100;
   localparam int RANDOM_REQS = 1700;
   localparam int PHASES      = 3;

   typedef struct packed {
      logic                  load_accepted;
      logic                  ran_valid;
      logic [RAN_SLOT_W-1:0] ran_slot;
      logic                  job_completed;
      time_type              job_turnaround;
      logic                  deadline_missed;
      sum_type               turnaround_total;
      time_type              tick_now;
   } outcome_type;

   class schedule_checker;
      logic        used [JOB_SLOTS];
      time_type    arrival [JOB_SLOTS];
      time_type    remaining [JOB_SLOTS];
      slack_type   slack [JOB_SLOTS];
      int          loaded;
      time_type    tick;
      sum_type     total;
      outcome_type expected_outcomes [$];
      int          errors;
      int          reports;
      int          loads;
      int          rejects;
      int          ticks;
      int          completions;
      int          misses;

      function new();
         foreach (used[i]) begin
            used[i]      = 1'b0;
            arrival[i]   = '0;
            remaining[i] = '0;
            slack[i]     = '0;
         end
         loaded      = 0;
         tick        = '0;
         total       = '0;
         errors      = 0;
         reports     = 0;
         loads       = 0;
         rejects     = 0;
         ticks       = 0;
         completions = 0;
         misses      = 0;
      endfunction

      function outcome_type predict_schedule(logic kind, time_type arr, time_type ex,
                                             time_type dl);
         outcome_type     o;
         int              best;
         int              i;
         logic [TIME_W:0] span;
         logic [SUM_W:0]  grown;
         o          = '0;
         o.tick_now = tick;
         if (kind == REQ_LOAD) begin
            loads++;
            if (loaded < JOB_SLOTS) begin
               used[loaded]      = 1'b1;
               arrival[loaded]   = arr;
               remaining[loaded] = ex;
               slack[loaded]     = slack_type'({1'b0, dl}) - slack_type'({1'b0, arr});
               loaded++;
               o.load_accepted = 1'b1;
            end else begin
               rejects++;
            end
         end else begin
            ticks++;
            best = -1;
            for (i = 0; i < JOB_SLOTS; i++) begin
               if (used[i] && arrival[i] <= tick && remaining[i] != '0) begin
                  if (slack[i] >= 0) slack[i] = slack[i] - slack_type'(1);
                  if (best < 0 || slack[i] < slack[best]) best = i;
               end
            end
            if (best >= 0) begin
               o.ran_valid = 1'b1;
               o.ran_slot  = best[RAN_SLOT_W-1:0];
               remaining[best] = remaining[best] - 1'b1;
               if (remaining[best] == '0) begin
                  span = {1'b0, tick} + 17'd1 - {1'b0, arrival[best]};
                  o.job_completed  = 1'b1;
                  o.job_turnaround = span[TIME_W] ? '1 : span[TIME_W-1:0];
                  grown = {1'b0, total} + {{(SUM_W-TIME_W+1){1'b0}}, o.job_turnaround};
                  total = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
                  completions++;
               end
               if (slack[best] == 0 && remaining[best] != '0) begin
                  o.deadline_missed = 1'b1;
                  misses++;
               end
            end
            tick = tick + 1'b1;
         end
         o.turnaround_total = total;
         return o;
      endfunction

      function void note_request(logic kind, time_type arr, time_type ex, time_type dl);
         outcome_type o;
         o                 = predict_schedule(kind, arr, ex, dl);
         expected_outcomes = {expected_outcomes, o};
      endfunction

      function void compare_field(string name, longint unsigned want_v, longint unsigned got_v);
         if (want_v != got_v) begin
            errors++;
            if (reports < REPORT_CAP) begin
               reports++;
               $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            end
         end
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            errors++;
            if (reports < REPORT_CAP) begin
               reports++;
               $display("%0t: result with no request outstanding", $time);
            end
            return;
         end
         want = expected_outcomes.pop_front();
         compare_field("load_accepted", want.load_accepted, got.load_accepted);
         compare_field("ran_valid", want.ran_valid, got.ran_valid);
         compare_field("ran_slot", want.ran_slot, got.ran_slot);
         compare_field("job_completed", want.job_completed, got.job_completed);
         compare_field("job_turnaround", want.job_turnaround, got.job_turnaround);
         compare_field("deadline_missed", want.deadline_missed, got.deadline_missed);
         compare_field("turnaround_total", want.turnaround_total, got.turnaround_total);
         compare_field("tick_now", want.tick_now, got.tick_now);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_type;
   time_type              req_arrival_time;
   time_type              req_exec_time;
   time_type              req_deadline_time;
   logic                  rsp_valid;
   logic                  rsp_load_accepted;
   logic                  rsp_ran_valid;
   logic [RAN_SLOT_W-1:0] rsp_ran_slot;
   logic                  rsp_job_completed;
   time_type              rsp_job_turnaround;
   logic                  rsp_deadline_missed;
   sum_type               rsp_turnaround_total;
   time_type              rsp_tick_now;

   schedule_checker sched;
   outcome_type     seen;
   int              idle_pct;
   int              ticks_sent;
   int              loads_sent;
   int              quiet_cycles;

   edf_job_scheduler #(.JOB_SLOTS(JOB_SLOTS)) DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_arrival_time     (req_arrival_time),
      .req_exec_time        (req_exec_time),
      .req_deadline_time    (req_deadline_time),
      .rsp_valid            (rsp_valid),
      .rsp_load_accepted    (rsp_load_accepted),
      .rsp_ran_valid        (rsp_ran_valid),
      .rsp_ran_slot         (rsp_ran_slot),
      .rsp_job_completed    (rsp_job_completed),
      .rsp_job_turnaround   (rsp_job_turnaround),
      .rsp_deadline_missed  (rsp_deadline_missed),
      .rsp_turnaround_total (rsp_turnaround_total),
      .rsp_tick_now         (rsp_tick_now)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sched.note_request(req_type, req_arrival_time, req_exec_time, req_deadline_time);
         if (rsp_valid) begin
            seen.load_accepted    = rsp_load_accepted;
            seen.ran_valid        = rsp_ran_valid;
            seen.ran_slot         = rsp_ran_slot;
            seen.job_completed    = rsp_job_completed;
            seen.job_turnaround   = rsp_job_turnaround;
            seen.deadline_missed  = rsp_deadline_missed;
            seen.turnaround_total = rsp_turnaround_total;
            seen.tick_now         = rsp_tick_now;
            sched.check_outcome(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_request(input logic kind, input time_type arr, input time_type ex,
                               input time_type dl);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_type          <= kind;
      req_arrival_time  <= arr;
      req_exec_time     <= ex;
      req_deadline_time <= dl;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      if (kind == REQ_TICK) ticks_sent++;
      else loads_sent++;
   endtask

   task automatic send_tick();
      send_request(REQ_TICK, time_type'($urandom), time_type'($urandom),
                   time_type'($urandom));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (sched.expected_outcomes.size() != 0);
   endtask

   initial begin
      int       idle_plan [PHASES];
      int       phase;
      int       n;
      time_type now;
      time_type arr;
      time_type ex;
      time_type dl;
      idle_plan         = '{0, 58, 15};
      sched             = new();
      reset             = 1'b1;
      start             = 1'b0;
      req_type          = REQ_LOAD;
      req_arrival_time  = '0;
      req_exec_time     = '0;
      req_deadline_time = '0;
      idle_pct          = 0;
      ticks_sent        = 0;
      loads_sent        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // short job due at once, a long job that soaks up idle ticks, a job with no work
      send_request(REQ_LOAD, 16'd0, 16'd1, 16'd0);
      send_request(REQ_LOAD, 16'd0, 16'hFFFF, 16'hFFFF);
      send_request(REQ_LOAD, 16'd0, 16'd0, 16'd7);
      send_tick();
      send_tick();
      wait_drained();

      now = ticks_sent[TIME_W-1:0];
      send_request(REQ_LOAD, 16'hFFFF, 16'd1, 16'd0);
      send_request(REQ_LOAD, now, 16'd4, now + 16'd1);
      send_request(REQ_LOAD, now + 16'd5, 16'd2, now + 16'd2);
      repeat (10) send_tick();
      wait_drained();

      for (phase = 0; phase < PHASES; phase++) begin
         idle_pct = idle_plan[phase];
         for (n = 0; n < RANDOM_REQS / PHASES; n++) begin
            now = ticks_sent[TIME_W-1:0];
            if ($urandom_range(99) < ((loads_sent < JOB_SLOTS) ? 5 : 15)) begin
               if (loads_sent < JOB_SLOTS) begin
                  arr = now + time_type'($urandom_range(30));
                  ex  = time_type'($urandom_range(120, 1));
                  dl  = arr + ex + time_type'($urandom_range(300))
                        - time_type'($urandom_range(150));
               end else begin
                  arr = time_type'($urandom);
                  ex  = time_type'($urandom_range(65535, 1));
                  dl  = time_type'($urandom);
               end
               send_request(REQ_LOAD, arr, ex, dl);
            end else begin
               send_tick();
            end
         end
         wait_drained();
      end

      repeat (JOB_SLOTS + 4) @(posedge clock);
      if (sched.expected_outcomes.size() != 0) begin
         sched.errors++;
         $display("%0t: %0d expected results never arrived", $time,
                  sched.expected_outcomes.size());
      end
      $display("Covered %0d loads (%0d turned away with the table full) and %0d ticks",
               sched.loads, sched.rejects, sched.ticks);
      $display("Saw %0d job completions, %0d deadline misses, final turnaround total %0d",
               sched.completions, sched.misses, sched.total);
      if (sched.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
